### sv/scb_pkg.sv
package scb_pkg;

  // input mode codes, carried on tuser
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic REG_DEVICE_ADDR = 1'b0;
  localparam logic REG_BYTE_GAP    = 1'b1;

  localparam logic [7:0] DEVICE_ADDR_RESET = 8'd120;
  localparam logic [7:0] BYTE_GAP_RESET    = 8'd50;

  // bus segment codes
  localparam logic [3:0] SEG_START = 4'd0;
  localparam logic [3:0] SEG_ID    = 4'd1;
  localparam logic [3:0] SEG_REG   = 4'd2;
  localparam logic [3:0] SEG_DATA  = 4'd3;
  localparam logic [3:0] SEG_IDR   = 4'd4;
  localparam logic [3:0] SEG_GAP   = 4'd5;
  localparam logic [3:0] SEG_STOP  = 4'd6;
  localparam logic [3:0] SEG_READ  = 4'd7;
  localparam logic [3:0] SEG_NACK  = 4'd8;
  localparam logic [3:0] SEG_END   = 4'd9;

  // segment lengths in ticks
  localparam logic [8:0] LEN_START = 9'd2;
  localparam logic [8:0] LEN_BYTE  = 9'd18;
  localparam logic [8:0] LEN_STOP  = 9'd3;
  localparam logic [8:0] LEN_READ  = 9'd16;
  localparam logic [8:0] LEN_NACK  = 9'd4;

  typedef struct packed {
    logic [4:0] phase;         // 0 idle, else sequence step plus one
    logic [3:0] bit_count;
    logic [7:0] delay_count;   // tick within the current segment
    logic [7:0] shift_byte;
    logic [7:0] held_reg_addr;
    logic [7:0] held_write_data;
    logic       is_read_op;
    logic       error_flag;
    logic [7:0] captured_byte;
    logic       clock_level;
    logic       data_level;
  } scb_state_t;

  localparam scb_state_t STATE_RESET = '{
    phase:           5'd0,
    bit_count:       4'd0,
    delay_count:     8'd0,
    shift_byte:      8'd0,
    held_reg_addr:   8'd0,
    held_write_data: 8'd0,
    is_read_op:      1'b0,
    error_flag:      1'b0,
    captured_byte:   8'd0,
    clock_level:     1'b1,
    data_level:      1'b1
  };

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
  } scb_res_t;

  // segment at a given sequence step, separate write and read sequences
  function automatic logic [3:0] seg_at(input logic is_read, input logic [4:0] step);
    logic [3:0] seg;
    seg = SEG_END;
    if (is_read) begin
      case (step)
        5'd0:    seg = SEG_START;
        5'd1:    seg = SEG_ID;
        5'd2:    seg = SEG_GAP;
        5'd3:    seg = SEG_REG;
        5'd4:    seg = SEG_GAP;
        5'd5:    seg = SEG_STOP;
        5'd6:    seg = SEG_GAP;
        5'd7:    seg = SEG_START;
        5'd8:    seg = SEG_IDR;
        5'd9:    seg = SEG_GAP;
        5'd10:   seg = SEG_READ;
        5'd11:   seg = SEG_NACK;
        5'd12:   seg = SEG_STOP;
        default: seg = SEG_END;
      endcase
    end else begin
      case (step)
        5'd0:    seg = SEG_START;
        5'd1:    seg = SEG_ID;
        5'd2:    seg = SEG_GAP;
        5'd3:    seg = SEG_REG;
        5'd4:    seg = SEG_GAP;
        5'd5:    seg = SEG_DATA;
        5'd6:    seg = SEG_STOP;
        default: seg = SEG_END;
      endcase
    end
    return seg;
  endfunction

endpackage

### sv/scb_step.sv
module scb_step (
  input  scb_pkg::scb_state_t state_i,
  input  logic [7:0]          device_addr_i,
  input  logic [7:0]          byte_gap_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          reg_addr_i,
  input  logic [7:0]          write_data_i,
  input  logic                sda_in_i,
  output scb_pkg::scb_state_t state_o,
  output scb_pkg::scb_res_t   res_o,
  output logic                start_o
);

  scb_pkg::scb_state_t st;
  logic [3:0] seg;
  logic [3:0] nseg;
  logic [4:0] nstep;
  logic [7:0] t;
  logic [8:0] len;
  logic [8:0] tnext;
  logic       start;
  logic       en;
  logic       done;

  always_comb begin
    st    = state_i;
    start = (state_i.phase == 5'd0) &&
            (mode_i == scb_pkg::MODE_WRITE || mode_i == scb_pkg::MODE_READ);
    en    = 1'b1;
    done  = 1'b0;
    len   = 9'd1;
    nstep = 5'd0;
    nseg  = scb_pkg::SEG_END;

    // a start makes this tick the first start tick
    if (start) begin
      st.is_read_op      = (mode_i == scb_pkg::MODE_READ);
      st.held_reg_addr   = reg_addr_i;
      st.held_write_data = write_data_i;
      if (mode_i == scb_pkg::MODE_WRITE) begin
        st.error_flag = 1'b0;
      end
      st.phase       = 5'd1;
      st.delay_count = 8'd0;
      st.bit_count   = 4'd0;
    end

    seg   = scb_pkg::seg_at(st.is_read_op, st.phase - 5'd1);
    t     = st.delay_count;
    tnext = {1'b0, t} + 9'd1;

    if (st.phase != 5'd0) begin
      case (seg)
        scb_pkg::SEG_START: begin
          len            = scb_pkg::LEN_START;
          st.clock_level = 1'b1;
          st.data_level  = (t == 8'd0);
        end
        scb_pkg::SEG_ID, scb_pkg::SEG_REG, scb_pkg::SEG_DATA, scb_pkg::SEG_IDR: begin
          len = scb_pkg::LEN_BYTE;
          if (t < 8'd16) begin
            if (!t[0]) begin
              st.data_level  = st.shift_byte[7];
              st.shift_byte  = {st.shift_byte[6:0], 1'b0};
              st.clock_level = 1'b0;
            end else begin
              st.clock_level = 1'b1;
              st.bit_count   = st.bit_count + 4'd1;
            end
          end else begin
            // acknowledge slot, sda released
            en             = 1'b0;
            st.clock_level = (t != 8'd16);
            if (t == 8'd17 && !st.is_read_op && sda_in_i) begin
              st.error_flag = 1'b1;
            end
          end
        end
        scb_pkg::SEG_GAP: begin
          len = {1'b0, byte_gap_i};
        end
        scb_pkg::SEG_STOP: begin
          len = scb_pkg::LEN_STOP;
          if (t == 8'd0) begin
            st.data_level = 1'b0;
          end else if (t == 8'd1) begin
            st.clock_level = 1'b1;
          end else begin
            st.data_level = 1'b1;
          end
        end
        scb_pkg::SEG_READ: begin
          len = scb_pkg::LEN_READ;
          en  = 1'b0;
          if (!t[0]) begin
            st.clock_level = 1'b0;
          end else begin
            st.clock_level = 1'b1;
            st.shift_byte  = {st.shift_byte[6:0], sda_in_i};
            st.bit_count   = st.bit_count + 4'd1;
            if (t == 8'd15) begin
              st.captured_byte = st.shift_byte;
            end
          end
        end
        scb_pkg::SEG_NACK: begin
          len = scb_pkg::LEN_NACK;
          if (t == 8'd1) begin
            st.data_level  = 1'b1;
            st.clock_level = 1'b1;
          end else if (t == 8'd2) begin
            st.clock_level = 1'b0;
          end else if (t == 8'd3) begin
            st.data_level = 1'b0;
          end
        end
        default: begin
          len = 9'd1;
        end
      endcase
    end

    // line levels of this tick
    res_o.scl_level  = st.clock_level;
    res_o.sda_drive  = st.data_level;
    res_o.sda_enable = en;
    res_o.busy_res   = (st.phase != 5'd0);

    if (st.phase != 5'd0) begin
      st.delay_count = tnext[7:0];
      if (tnext >= len) begin
        if (seg != scb_pkg::SEG_GAP && seg != scb_pkg::SEG_STOP &&
            seg != scb_pkg::SEG_NACK) begin
          st.clock_level = 1'b0;
        end
        // next step, a zero gap is skipped
        nstep = st.phase;
        nseg  = scb_pkg::seg_at(st.is_read_op, nstep);
        if (nseg == scb_pkg::SEG_GAP && byte_gap_i == 8'd0) begin
          nstep = nstep + 5'd1;
          nseg  = scb_pkg::seg_at(st.is_read_op, nstep);
        end
        st.delay_count = 8'd0;
        st.bit_count   = 4'd0;
        if (nseg == scb_pkg::SEG_END) begin
          st.phase = 5'd0;
          done     = 1'b1;
        end else begin
          st.phase = nstep + 5'd1;
          case (nseg)
            scb_pkg::SEG_ID:   st.shift_byte = device_addr_i;
            scb_pkg::SEG_IDR:  st.shift_byte = device_addr_i | 8'h01;
            scb_pkg::SEG_REG:  st.shift_byte = st.held_reg_addr;
            scb_pkg::SEG_DATA: st.shift_byte = st.held_write_data;
            scb_pkg::SEG_READ: st.shift_byte = 8'd0;
            default:           st.shift_byte = st.shift_byte;
          endcase
        end
      end
    end

    res_o.done_res  = done;
    res_o.ack_error = st.error_flag;
    res_o.read_data = st.captured_byte;
    state_o         = st;
    start_o         = start;
  end

endmodule

### sv/sccb_register_access_master.sv
// an accepted beat passes the input register and then the result register
// throughput: one tick beat per cycle unless stalled, set by the combinational sequencer step
// back pressure on the master side stalls the input register without losing beats
// reset (rst_ni low, asynchronous): bus idle with scl and sda high and driven,
//   error flag and read byte cleared, device byte 120, byte gap 50 ticks
module sccb_register_access_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick beats in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // reg_addr[7:0], write_data[15:8], sda_in[16], zero pad
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  // result beats out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // scl_level[0], sda_drive[1], sda_enable[2], busy_res[3],
                                      // done_res[4], ack_error[5], read_data[13:6], zero pad
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  // configuration registers
  logic [7:0] device_addr_q;
  logic [7:0] byte_gap_q;

  // input register
  logic       in_valid_q;
  logic [1:0] in_mode_q;
  logic [7:0] in_reg_addr_q;
  logic [7:0] in_write_data_q;
  logic       in_sda_q;

  // sequencer state
  scb_pkg::scb_state_t state_q;
  scb_pkg::scb_state_t state_d;

  // result register
  logic              out_valid_q;
  scb_pkg::scb_res_t res_q;
  scb_pkg::scb_res_t res_d;

  logic advance;
  logic in_take;
  logic start;

  // the held beat moves to the result register when that one is free or drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_addr_q <= scb_pkg::DEVICE_ADDR_RESET;
      byte_gap_q    <= scb_pkg::BYTE_GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        scb_pkg::REG_DEVICE_ADDR: device_addr_q <= cfg_data_i;
        scb_pkg::REG_BYTE_GAP:    byte_gap_q    <= cfg_data_i;
        default:                  device_addr_q <= device_addr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q       <= s_axis_tuser;
      in_reg_addr_q   <= s_axis_tdata[7:0];
      in_write_data_q <= s_axis_tdata[15:8];
      in_sda_q        <= s_axis_tdata[16];
    end
  end

  // one bus tick per beat: segment action, line levels and step advance
  scb_step u_step (
    .state_i       (state_q),
    .device_addr_i (device_addr_q),
    .byte_gap_i    (byte_gap_q),
    .mode_i        (in_mode_q),
    .reg_addr_i    (in_reg_addr_q),
    .write_data_i  (in_write_data_q),
    .sda_in_i      (in_sda_q),
    .state_o       (state_d),
    .res_o         (res_d),
    .start_o       (start)
  );

  // state moves only when a tick beat is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scb_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.read_data, res_q.ack_error, res_q.done_res,
                          res_q.busy_res, res_q.sda_enable, res_q.sda_drive, res_q.scl_level};

`ifndef SYNTHESIS
  // an idle tick with no start reports not busy
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.phase == 5'd0 && !start |=> !res_q.busy_res)
    else $error("idle tick reported busy");

  // a finished transaction leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.done_res |=> state_q.phase == 5'd0)
    else $error("sequencer not idle after done");

  // sda is only released inside a transaction
  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.sda_enable |-> res_q.busy_res)
    else $error("sda released while idle");

  // an empty result register never blocks the input side
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");
`endif

endmodule
